@@ hw/rtl/lscf_pkg.sv @@
package lscf_pkg;

  // fixed-point format and set size
  localparam int FRAC     = 20;
  localparam int MAX_PTS  = 256;
  localparam int IDX_W    = $clog2(MAX_PTS);
  localparam int CNT_W    = IDX_W + 1;

  // divider geometry: dividend up to a 62-bit magnitude shifted up by FRAC
  localparam int DIV_DW   = 62 + FRAC;
  localparam int DIV_VW   = 62;
  localparam int QUOT_W   = 64;

  // normalization bound and output limits
  localparam int NORM_BITS         = 30;
  localparam logic [31:0] LIM      = 32'd1 << NORM_BITS;
  localparam logic [63:0] RSQ_MAX  = 64'h0FFF_FFFF;
  localparam logic [31:0] RAD_MAX  = 32'h00FF_FFFF;

  // fit status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FEW      = 3'd1;
  localparam logic [2:0] ST_SINGULAR = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_SAT      = 3'd4;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  // round a Q2F value to QF, half up
  function automatic logic [63:0] round_q(logic [63:0] v);
    return (v >> FRAC) + 64'(v[FRAC-1]);
  endfunction

endpackage

@@ hw/rtl/lscf_div.sv @@
module lscf_div import lscf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [DIV_DW-1:0] dividend,
  input  logic [DIV_VW-1:0] divisor,
  output logic [QUOT_W-1:0] quot,
  output logic [DIV_VW-1:0] rem,
  output div_stat_t         stat
);

  localparam int STEP_W = $clog2(DIV_DW);

  logic [DIV_DW-1:0] dvd_r;
  logic [DIV_VW-1:0] dvs_r;
  logic [DIV_VW-1:0] rem_r;
  logic [QUOT_W-1:0] quot_r;
  logic              ovf_r;
  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;

  logic [DIV_VW:0]   shifted;
  logic [DIV_VW:0]   diff;
  logic              ge;

  // one restoring step: bring down the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem_r, dvd_r[DIV_DW-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = shifted >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: load on go, shift one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (go) begin
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
      ovf_r  <= 1'b0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[DIV_DW-2:0], 1'b0};
      rem_r  <= ge ? diff[DIV_VW-1:0] : shifted[DIV_VW-1:0];
      quot_r <= {quot_r[QUOT_W-2:0], ge};
      ovf_r  <= ovf_r | quot_r[QUOT_W-1];
    end
  end

  assign quot      = quot_r;
  assign rem       = rem_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

@@ hw/rtl/lscf_sqrt.sv @@
module lscf_sqrt import lscf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] op_r;
  logic [63:0] res_r;
  logic [63:0] one_r;
  logic        busy_r;
  logic        done_r;
  logic [4:0]  step_r;
  logic [63:0] trial;

  assign trial = res_r + one_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 5'd1;
        if (step_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // digit-by-digit root, two radicand bits per cycle
  always_ff @(posedge clk) begin
    if (go) begin
      op_r  <= radicand;
      res_r <= '0;
      one_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (op_r >= trial) begin
        op_r  <= op_r - trial;
        res_r <= (res_r >> 1) + one_r;
      end else begin
        res_r <= res_r >> 1;
      end
      one_r <= one_r >> 2;
    end
  end

  // round to nearest
  assign root = res_r[31:0] + 32'(op_r > res_r);
  assign done = done_r;

endmodule

@@ hw/rtl/least_squares_circle_fit_top.sv @@
// Channel  Ports                                  Handshake
// input    in_point_x, in_point_y, in_last_point  start high while busy low
// result   out_center_x/_y, out_radius_squared,   out_valid, one cycle
//          out_radius, out_fit_status
//
// A point that is not last leaves the block idle and ready for the next. A last
// point starts the fit: a moment pass over the N stored points (one shared
// 32x32 multiplier, 7 products per point), five 82-step divisions, normalize
// shifts until every magnitude fits, and a 32-step root.
// Synchronous active-low reset clears the set; the point store holds no reset.
// The result strobe cannot be stalled.
module least_squares_circle_fit_top import lscf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] in_point_x,
  input  logic signed [23:0] in_point_y,
  input  logic               in_last_point,
  output logic               out_valid,
  output logic signed [23:0] out_center_x,
  output logic signed [23:0] out_center_y,
  output logic [27:0]        out_radius_squared,
  output logic [23:0]        out_radius,
  output logic [2:0]         out_fit_status
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_DGO  = 5'd2;
  localparam logic [4:0] S_DWT  = 5'd3;
  localparam logic [4:0] S_RD   = 5'd4;
  localparam logic [4:0] S_UV   = 5'd5;
  localparam logic [4:0] S_MUL  = 5'd6;
  localparam logic [4:0] S_NRM0 = 5'd7;
  localparam logic [4:0] S_NRM1 = 5'd8;
  localparam logic [4:0] S_NRM2 = 5'd9;
  localparam logic [4:0] S_DET0 = 5'd10;
  localparam logic [4:0] S_DET1 = 5'd11;
  localparam logic [4:0] S_DET2 = 5'd12;
  localparam logic [4:0] S_DET3 = 5'd13;
  localparam logic [4:0] S_DET4 = 5'd14;
  localparam logic [4:0] S_DET5 = 5'd15;
  localparam logic [4:0] S_DET6 = 5'd16;
  localparam logic [4:0] S_R2A  = 5'd17;
  localparam logic [4:0] S_R2B  = 5'd18;
  localparam logic [4:0] S_R2C  = 5'd19;
  localparam logic [4:0] S_SQG  = 5'd20;
  localparam logic [4:0] S_SQW  = 5'd21;
  localparam logic [4:0] S_OUT  = 5'd22;

  localparam logic [2:0] DV_MX  = 3'd0;
  localparam logic [2:0] DV_MY  = 3'd1;
  localparam logic [2:0] DV_UC  = 3'd2;
  localparam logic [2:0] DV_VC  = 3'd3;
  localparam logic [2:0] DV_SPR = 3'd4;

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // control
  logic [4:0]         state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               ovf_r;
  logic signed [32:0] sx_r, sy_r;
  logic [CNT_W-1:0]   idx_r;
  logic [2:0]         k_r;
  logic [2:0]         dsel_r;
  logic               sat_r;
  logic               out_valid_r;

  // point store
  logic signed [23:0] x_mem [MAX_PTS];
  logic signed [23:0] y_mem [MAX_PTS];
  logic signed [23:0] rdx_r, rdy_r;

  // datapath
  logic signed [24:0] xa_r, ya_r, u_r, v_r;
  logic [28:0]        uu_r, vv_r;
  logic signed [63:0] suu_r, suv_r, svv_r, t0_r, t1_r, t2_r, t3_r;
  logic signed [63:0] b0_r, b1_r, a_r, c_r, d_r, p_r, q_r;
  logic [63:0]        mor_r;
  logic signed [63:0] mul_r, t_r, det_r, n1_r, n2_r;
  logic signed [31:0] uc_r, vc_r;
  logic [63:0]        spr_r, r2_r;

  // result registers
  logic signed [23:0] cx_r, cy_r;
  logic [27:0]        rsq_r;
  logic [23:0]        rad_r;
  logic [2:0]         st_r;

  logic               accept;
  logic               wr_ok;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] b0_sum, b1_sum;

  logic               div_go;
  logic [DIV_DW-1:0]  div_dvd;
  logic [DIV_VW-1:0]  div_dvs;
  logic [QUOT_W-1:0]  dquot;
  logic [DIV_VW-1:0]  drem;
  div_stat_t          dstat;
  logic [32:0]        sx_mag, sy_mag;
  logic               rnd;
  logic [64:0]        qsum;
  logic               dsat;
  logic [31:0]        qmag;
  logic               qneg;
  logic signed [31:0] qsigned;
  logic signed [24:0] mean_val;

  logic               sq_go;
  logic               sq_done;
  logic [31:0]        sq_root;

  logic               fin;
  logic [2:0]         fin_st;
  logic signed [23:0] fin_cx, fin_cy;
  logic [27:0]        fin_rsq;
  logic [23:0]        fin_rad;
  logic signed [32:0] cx_sum, cy_sum;
  logic               cx_sat, cy_sat, rsq_sat, rad_sat;
  logic [63:0]        rsq_full;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign wr_ok  = cnt_r < CNT_W'(MAX_PTS);

  // store each word while there is room
  always_ff @(posedge clk) begin
    if (accept && wr_ok) begin
      x_mem[cnt_r[IDX_W-1:0]] <= in_point_x;
      y_mem[cnt_r[IDX_W-1:0]] <= in_point_y;
    end
    rdx_r <= x_mem[idx_r[IDX_W-1:0]];
    rdy_r <= y_mem[idx_r[IDX_W-1:0]];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL: begin
        case (k_r)
          3'd0: begin mul_a = 32'(u_r); mul_b = 32'(u_r); end
          3'd1: begin mul_a = 32'(v_r); mul_b = 32'(v_r); end
          3'd2: begin mul_a = 32'(u_r); mul_b = 32'(v_r); end
          3'd3: begin mul_a = 32'(u_r); mul_b = {3'b0, uu_r}; end
          3'd4: begin mul_a = 32'(v_r); mul_b = {3'b0, vv_r}; end
          3'd5: begin mul_a = 32'(u_r); mul_b = {3'b0, vv_r}; end
          3'd6: begin mul_a = 32'(v_r); mul_b = {3'b0, uu_r}; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_DET0: begin mul_a = a_r[31:0]; mul_b = d_r[31:0]; end
      S_DET1: begin mul_a = c_r[31:0]; mul_b = c_r[31:0]; end
      S_DET2: begin mul_a = p_r[31:0]; mul_b = d_r[31:0]; end
      S_DET3: begin mul_a = q_r[31:0]; mul_b = c_r[31:0]; end
      S_DET4: begin mul_a = q_r[31:0]; mul_b = a_r[31:0]; end
      S_DET5: begin mul_a = p_r[31:0]; mul_b = c_r[31:0]; end
      S_R2A:  begin mul_a = uc_r; mul_b = uc_r; end
      S_R2B:  begin mul_a = vc_r; mul_b = vc_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // divider operand select
  always_comb begin
    sx_mag  = sx_r[32] ? 33'(-sx_r) : 33'(sx_r);
    sy_mag  = sy_r[32] ? 33'(-sy_r) : 33'(sy_r);
    div_go  = (state_r == S_DGO);
    div_dvd = '0;
    div_dvs = '0;
    case (dsel_r)
      DV_MX: begin
        div_dvd = DIV_DW'({sx_mag, 1'b0}) + DIV_DW'(cnt_r);
        div_dvs = DIV_VW'({cnt_r, 1'b0});
      end
      DV_MY: begin
        div_dvd = DIV_DW'({sy_mag, 1'b0}) + DIV_DW'(cnt_r);
        div_dvs = DIV_VW'({cnt_r, 1'b0});
      end
      DV_UC: begin
        div_dvd = DIV_DW'({mag64(n1_r), {FRAC{1'b0}}});
        div_dvs = det_r[DIV_VW-1:0];
      end
      DV_VC: begin
        div_dvd = DIV_DW'({mag64(n2_r), {FRAC{1'b0}}});
        div_dvs = det_r[DIV_VW-1:0];
      end
      DV_SPR: begin
        div_dvd = DIV_DW'(64'(suu_r + svv_r)) + DIV_DW'(cnt_r[CNT_W-1:1]);
        div_dvs = DIV_VW'(cnt_r);
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  lscf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quot     (dquot),
    .rem      (drem),
    .stat     (dstat)
  );

  // round and clamp the centre offset quotient; sign the mean
  always_comb begin
    rnd      = drem >= (det_r[DIV_VW-1:0] - drem);
    qsum     = {1'b0, dquot} + 65'(rnd);
    dsat     = dstat.ovf || (qsum > 65'(LIM));
    qmag     = dsat ? LIM : qsum[31:0];
    qneg     = (dsel_r == DV_UC) ? n1_r[63] : n2_r[63];
    qsigned  = qneg ? -$signed(qmag) : $signed(qmag);
    mean_val = ((dsel_r == DV_MX) ? sx_r[32] : sy_r[32]) ?
               -$signed(25'(dquot[23:0])) : $signed(25'(dquot[23:0]));
  end

  assign sq_go = (state_r == S_SQG);

  lscf_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (sq_go),
    .radicand (r2_r),
    .root     (sq_root),
    .done     (sq_done)
  );

  assign b0_sum = t0_r + t2_r;
  assign b1_sum = t1_r + t3_r;

  // result assembly and the finish decision
  always_comb begin
    cx_sum   = 33'(uc_r) + 33'(xa_r);
    cy_sum   = 33'(vc_r) + 33'(ya_r);
    cx_sat   = (cx_sum > 33'sd8388607) || (cx_sum < -33'sd8388608);
    cy_sat   = (cy_sum > 33'sd8388607) || (cy_sum < -33'sd8388608);
    rsq_full = round_q(r2_r);
    rsq_sat  = rsq_full > RSQ_MAX;
    rad_sat  = sq_root > RAD_MAX;
    fin      = 1'b0;
    fin_st   = ST_OK;
    fin_cx   = '0;
    fin_cy   = '0;
    fin_rsq  = '0;
    fin_rad  = '0;
    unique case (state_r)
      S_CHK: begin
        if (ovf_r) begin
          fin    = 1'b1;
          fin_st = ST_OVERFLOW;
        end else if (cnt_r < CNT_W'(3)) begin
          fin    = 1'b1;
          fin_st = ST_FEW;
        end
      end
      S_DET4: begin
        if (det_r <= 64'sd0) begin
          fin    = 1'b1;
          fin_st = ST_SINGULAR;
        end
      end
      S_OUT: begin
        fin     = 1'b1;
        fin_cx  = cx_sat ? (cx_sum[32] ? -24'sd8388608 : 24'sd8388607) : cx_sum[23:0];
        fin_cy  = cy_sat ? (cy_sum[32] ? -24'sd8388608 : 24'sd8388607) : cy_sum[23:0];
        fin_rsq = rsq_sat ? RSQ_MAX[27:0] : rsq_full[27:0];
        fin_rad = rad_sat ? RAD_MAX[23:0] : sq_root[23:0];
        fin_st  = (sat_r || cx_sat || cy_sat || rsq_sat || rad_sat) ? ST_SAT : ST_OK;
      end
      default: fin = 1'b0;
    endcase
  end

  // sequencer and set bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      sx_r        <= '0;
      sy_r        <= '0;
      idx_r       <= '0;
      k_r         <= '0;
      dsel_r      <= DV_MX;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (fin) begin
        out_valid_r <= 1'b1;
        state_r     <= S_IDLE;
        cnt_r       <= '0;
        ovf_r       <= 1'b0;
        sx_r        <= '0;
        sy_r        <= '0;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (accept) begin
              if (wr_ok) begin
                cnt_r <= cnt_r + CNT_W'(1);
                sx_r  <= sx_r + 33'(in_point_x);
                sy_r  <= sy_r + 33'(in_point_y);
              end else begin
                ovf_r <= 1'b1;
              end
              if (in_last_point) state_r <= S_CHK;
            end
          end
          S_CHK: begin
            sat_r   <= 1'b0;
            dsel_r  <= DV_MX;
            state_r <= S_DGO;
          end
          S_DGO: state_r <= S_DWT;
          S_DWT: begin
            if (dstat.done) begin
              case (dsel_r)
                DV_MX: begin
                  dsel_r  <= DV_MY;
                  state_r <= S_DGO;
                end
                DV_MY: begin
                  idx_r   <= '0;
                  state_r <= S_RD;
                end
                DV_UC: begin
                  sat_r   <= sat_r | dsat;
                  dsel_r  <= DV_VC;
                  state_r <= S_DGO;
                end
                DV_VC: begin
                  sat_r   <= sat_r | dsat;
                  dsel_r  <= DV_SPR;
                  state_r <= S_DGO;
                end
                default: state_r <= S_R2A;
              endcase
            end
          end
          S_RD: state_r <= S_UV;
          S_UV: begin
            k_r     <= '0;
            state_r <= S_MUL;
          end
          S_MUL: begin
            k_r <= k_r + 3'd1;
            if (k_r == 3'd7) begin
              idx_r   <= idx_r + CNT_W'(1);
              state_r <= (idx_r + CNT_W'(1) == cnt_r) ? S_NRM0 : S_RD;
            end
          end
          S_NRM0: state_r <= S_NRM1;
          S_NRM1: state_r <= S_NRM2;
          S_NRM2: begin
            if (mor_r[63:NORM_BITS] == '0) state_r <= S_DET0;
          end
          S_DET0: state_r <= S_DET1;
          S_DET1: state_r <= S_DET2;
          S_DET2: state_r <= S_DET3;
          S_DET3: state_r <= S_DET4;
          S_DET4: state_r <= S_DET5;
          S_DET5: state_r <= S_DET6;
          S_DET6: begin
            dsel_r  <= DV_UC;
            state_r <= S_DGO;
          end
          S_R2A: state_r <= S_R2B;
          S_R2B: state_r <= S_R2C;
          S_R2C: state_r <= S_SQG;
          S_SQG: state_r <= S_SQW;
          S_SQW: begin
            if (sq_done) state_r <= S_OUT;
          end
          S_OUT: state_r <= S_IDLE;
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (fin) begin
      cx_r  <= fin_cx;
      cy_r  <= fin_cy;
      rsq_r <= fin_rsq;
      rad_r <= fin_rad;
      st_r  <= fin_st;
    end
    case (state_r)
      S_DWT: begin
        if (dstat.done) begin
          case (dsel_r)
            DV_MX: xa_r <= mean_val;
            DV_MY: begin
              ya_r  <= mean_val;
              suu_r <= '0;
              suv_r <= '0;
              svv_r <= '0;
              t0_r  <= '0;
              t1_r  <= '0;
              t2_r  <= '0;
              t3_r  <= '0;
            end
            DV_UC:   uc_r  <= qsigned;
            DV_VC:   vc_r  <= qsigned;
            default: spr_r <= dquot;
          endcase
        end
      end
      S_UV: begin
        u_r <= {rdx_r[23], rdx_r} - xa_r;
        v_r <= {rdy_r[23], rdy_r} - ya_r;
      end
      // accumulate the product issued one step earlier
      S_MUL: begin
        case (k_r)
          3'd1: begin
            suu_r <= suu_r + mul_r;
            uu_r  <= 29'(round_q(mul_r));
          end
          3'd2: begin
            svv_r <= svv_r + mul_r;
            vv_r  <= 29'(round_q(mul_r));
          end
          3'd3: suv_r <= suv_r + mul_r;
          3'd4: t0_r  <= t0_r + mul_r;
          3'd5: t1_r  <= t1_r + mul_r;
          3'd6: t2_r  <= t2_r + mul_r;
          3'd7: t3_r  <= t3_r + mul_r;
          default: t_r <= t_r;
        endcase
      end
      S_NRM0: begin
        b0_r <= b0_sum >>> 1;
        b1_r <= b1_sum >>> 1;
      end
      S_NRM1: begin
        a_r   <= suu_r;
        c_r   <= suv_r;
        d_r   <= svv_r;
        p_r   <= b0_r;
        q_r   <= b1_r;
        mor_r <= mag64(suu_r) | mag64(suv_r) | mag64(svv_r) | mag64(b0_r) | mag64(b1_r);
      end
      // shift the system down one bit until every magnitude fits
      S_NRM2: begin
        if (mor_r[63:NORM_BITS] != '0) begin
          a_r   <= a_r >>> 1;
          c_r   <= c_r >>> 1;
          d_r   <= d_r >>> 1;
          p_r   <= p_r >>> 1;
          q_r   <= q_r >>> 1;
          mor_r <= mor_r >> 1;
        end
      end
      S_DET1: t_r   <= mul_r;
      S_DET2: det_r <= t_r - mul_r;
      S_DET3: t_r   <= mul_r;
      S_DET4: n1_r  <= t_r - mul_r;
      S_DET5: t_r   <= mul_r;
      S_DET6: n2_r  <= t_r - mul_r;
      S_R2B:  t_r   <= mul_r;
      S_R2C:  r2_r  <= 64'(t_r + mul_r) + spr_r;
      default: t_r  <= t_r;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_center_x       = cx_r;
  assign out_center_y       = cy_r;
  assign out_radius_squared = rsq_r;
  assign out_radius         = rad_r;
  assign out_fit_status     = st_r;

`ifndef SYNTHESIS
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result word without a fit in progress");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fit_status == ST_FEW || out_fit_status == ST_SINGULAR ||
                  out_fit_status == ST_OVERFLOW)
    |-> out_center_x == '0 && out_center_y == '0 &&
        out_radius_squared == '0 && out_radius == '0)
    else $error("error status with nonzero fields");

  a_plain_point_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_point |=> !busy && !out_valid)
    else $error("non-final word stalled the block");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fit_status <= ST_SAT)
    else $error("status code out of range");
`endif

endmodule

@@ test/lscf_fit_checker.sv @@
// Watch the point and result channels, predict each fit and compare.
module lscf_fit_checker import lscf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [23:0] in_point_x,
  input  logic signed [23:0] in_point_y,
  input  logic               in_last_point,
  input  logic               out_valid,
  input  logic signed [23:0] out_center_x,
  input  logic signed [23:0] out_center_y,
  input  logic [27:0]        out_radius_squared,
  input  logic [23:0]        out_radius,
  input  logic [2:0]         out_fit_status,
  output int                 errors,
  output int                 pending
);

  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

  typedef struct packed {
    logic [23:0] cx;
    logic [23:0] cy;
    logic [27:0] rsq;
    logic [23:0] rad;
    logic [2:0]  st;
  } fit_word_t;

  longint    px [MAX_PTS];
  longint    py [MAX_PTS];
  int        npts;
  longint    sum_x, sum_y;
  bit        store_full;
  fit_word_t fit_q[$];

  function automatic longint add_sat(longint a, longint b, inout bit sat);
    longint r;
    r = a + b;
    if (a >= 0 && b > 0 && r < 0) begin
      sat = 1;
      return S64_MAX;
    end
    if (a < 0 && b < 0 && r >= 0) begin
      sat = 1;
      return S64_MIN;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint mul_sat(longint a, longint b, inout bit sat);
    logic [63:0] ma, mb;
    bit neg;
    ma  = mag(a);
    mb  = mag(b);
    neg = (a < 0) != (b < 0);
    if (ma != 0 && mb > 64'(S64_MAX) / ma) begin
      sat = 1;
      return neg ? -S64_MAX : S64_MAX;
    end
    return neg ? -longint'(ma * mb) : longint'(ma * mb);
  endfunction

  // drop Q2F to QF, half up
  function automatic longint to_qf(logic [63:0] v);
    return longint'((v >> FRAC) + 64'(v[FRAC-1]));
  endfunction

  function automatic longint mean_of(longint s, int n);
    logic [63:0] q;
    q = (2 * mag(s) + 64'(n)) / (2 * 64'(n));
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  // num * 2^F / det, magnitude rounded and clamped to 2^30
  function automatic longint center_off(longint num, longint det, inout bit sat);
    logic [127:0] dvd, q, rem, dd;
    dd  = 128'(det);
    dvd = 128'(mag(num)) << FRAC;
    q   = dvd / dd;
    rem = dvd % dd;
    if (rem >= dd - rem) q = q + 1;
    if (q > 128'(LIM)) begin
      sat = 1;
      q = 128'(LIM);
    end
    return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [63:0] root_round(logic [63:0] x);
    logic [63:0] r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    if (x - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic longint clip24(longint v, inout bit sat);
    if (v > 64'sh7FFFFF) begin
      sat = 1;
      return 64'sh7FFFFF;
    end
    if (v < -64'sh800000) begin
      sat = 1;
      return -64'sh800000;
    end
    return v;
  endfunction

  // solve the normal equations over the stored set
  function automatic fit_word_t fit_set();
    fit_word_t w;
    bit sat;
    longint xa, ya, u, v, uu, vv, suu, suv, svv, t0, t1, t2, t3;
    longint b0, b1, a, c, d, p, q, det, uc, vc, cx, cy, r2;
    logic [63:0] m, spread, rsq, rad;
    int s;
    w = '0;
    sat = 0;
    if (store_full) begin
      w.st = ST_OVERFLOW;
      return w;
    end
    if (npts < 3) begin
      w.st = ST_FEW;
      return w;
    end
    xa = mean_of(sum_x, npts);
    ya = mean_of(sum_y, npts);
    suu = 0; suv = 0; svv = 0; t0 = 0; t1 = 0; t2 = 0; t3 = 0;
    for (int i = 0; i < npts; i++) begin
      u  = px[i] - xa;
      v  = py[i] - ya;
      uu = to_qf(64'(u * u));
      vv = to_qf(64'(v * v));
      suu = add_sat(suu, u * u, sat);
      suv = add_sat(suv, u * v, sat);
      svv = add_sat(svv, v * v, sat);
      t0 = add_sat(t0, mul_sat(u, uu, sat), sat);
      t1 = add_sat(t1, mul_sat(v, vv, sat), sat);
      t2 = add_sat(t2, mul_sat(u, vv, sat), sat);
      t3 = add_sat(t3, mul_sat(v, uu, sat), sat);
    end
    b0 = add_sat(t0, t2, sat) >>> 1;
    b1 = add_sat(t1, t3, sat) >>> 1;
    m = mag(suu);
    if (mag(suv) > m) m = mag(suv);
    if (mag(svv) > m) m = mag(svv);
    if (mag(b0) > m) m = mag(b0);
    if (mag(b1) > m) m = mag(b1);
    s = 0;
    while ((m >> s) >= 64'(LIM)) s++;
    a = suu >>> s;
    c = suv >>> s;
    d = svv >>> s;
    p = b0 >>> s;
    q = b1 >>> s;
    det = a * d - c * c;
    if (det <= 0) begin
      w.st = ST_SINGULAR;
      return w;
    end
    uc = center_off(p * d - q * c, det, sat);
    vc = center_off(q * a - p * c, det, sat);
    cx = clip24(uc + xa, sat);
    cy = clip24(vc + ya, sat);
    spread = (64'(add_sat(suu, svv, sat)) + 64'(npts / 2)) / 64'(npts);
    r2  = add_sat(uc * uc + vc * vc, longint'(spread), sat);
    rsq = (64'(r2) >> FRAC) + 64'(r2[FRAC-1]);
    if (rsq > RSQ_MAX) begin
      sat = 1;
      rsq = RSQ_MAX;
    end
    rad = root_round(64'(r2));
    if (rad > 64'(RAD_MAX)) begin
      sat = 1;
      rad = 64'(RAD_MAX);
    end
    w.cx  = cx[23:0];
    w.cy  = cy[23:0];
    w.rsq = rsq[27:0];
    w.rad = rad[23:0];
    w.st  = sat ? ST_SAT : ST_OK;
    return w;
  endfunction

  assign pending = fit_q.size();

  // track accepted points and close sets
  always @(posedge clk) begin
    if (!rst_n) begin
      npts = 0;
      sum_x = 0;
      sum_y = 0;
      store_full = 0;
    end else if (start && !busy) begin
      if (npts < MAX_PTS) begin
        px[npts] = longint'(in_point_x);
        py[npts] = longint'(in_point_y);
        sum_x = sum_x + longint'(in_point_x);
        sum_y = sum_y + longint'(in_point_y);
        npts = npts + 1;
      end else begin
        store_full = 1;
      end
      if (in_last_point) begin
        fit_q = {fit_q, fit_set()};
        npts = 0;
        sum_x = 0;
        sum_y = 0;
        store_full = 0;
      end
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    fit_word_t e;
    if (!rst_n) begin
      errors <= 0;
    end else if (out_valid) begin
      if (fit_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result word: status %0d", out_fit_status);
      end else begin
        e = fit_q.pop_front();
        if (e.cx !== out_center_x || e.cy !== out_center_y || e.rsq !== out_radius_squared
            || e.rad !== out_radius || e.st !== out_fit_status) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("fit mismatch: exp cx %h cy %h r2 %h r %h st %0d, got %h %h %h %h %0d",
                     e.cx, e.cy, e.rsq, e.rad, e.st, out_center_x, out_center_y,
                     out_radius_squared, out_radius, out_fit_status);
        end
      end
    end
  end

endmodule

@@ test/tb_least_squares_circle_fit_top.sv @@
module tb_least_squares_circle_fit_top;
  import lscf_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [23:0] in_point_x;
  logic signed [23:0] in_point_y;
  logic               in_last_point;
  logic               out_valid;
  logic signed [23:0] out_center_x;
  logic signed [23:0] out_center_y;
  logic [27:0]        out_radius_squared;
  logic [23:0]        out_radius;
  logic [2:0]         out_fit_status;
  int                 errors;
  int                 pending;
  int                 cycles;
  int                 sent;
  bit                 calm;

  least_squares_circle_fit_top dut (.*);

  lscf_fit_checker chk (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // drive one point word; called at a falling edge, returns at one
  task automatic send_point(logic signed [23:0] x, logic signed [23:0] y, logic last);
    bit taken;
    while (!calm && $urandom_range(99) < 14) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_point_x = x;
    in_point_y = y;
    in_last_point = last;
    taken = 0;
    while (!taken) begin
      taken = !busy;
      @(negedge clk);
    end
    sent++;
  endtask

  function automatic logic signed [23:0] clamp_pt(longint v);
    if (v > 64'sh7FFFFF) return 24'sh7FFFFF;
    if (v < -64'sh800000) return -24'sh800000;
    return v[23:0];
  endfunction

  // one set of n points: full range, a cluster, or all points equal
  task automatic send_set(int n, int shape);
    longint bx, by, sp;
    logic signed [23:0] x, y;
    bx = longint'($signed(24'($urandom))) >>> $urandom_range(0, 4);
    by = longint'($signed(24'($urandom))) >>> $urandom_range(0, 4);
    sp = longint'(1) << $urandom_range(4, 22);
    for (int i = 0; i < n; i++) begin
      case (shape)
        0: begin
          x = 24'($urandom);
          y = 24'($urandom);
        end
        1: begin
          x = clamp_pt(bx + longint'($urandom_range(0, 32'(2 * sp))) - sp);
          y = clamp_pt(by + longint'($urandom_range(0, 32'(2 * sp))) - sp);
        end
        default: begin
          x = bx[23:0];
          y = by[23:0];
        end
      endcase
      send_point(x, y, i == n - 1);
    end
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    start = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_last_point = 1'b0;
    sent = 0;
    calm = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes, short sets, equal and collinear points
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 0);
    send_point(-24'sh800000, 24'sh7FFFFF, 0);
    send_point(24'sh7FFFFF, -24'sh800000, 1);
    send_point(-24'sh800000, -24'sh800000, 0);
    send_point(24'sh000000, 24'sh7FFFFF, 0);
    send_point(-24'sh800000, 24'sh000000, 1);
    send_point(24'sh100000, 24'sh000000, 1);
    send_point(24'sh100000, 24'sh000000, 0);
    send_point(24'sh000000, 24'sh100000, 1);
    send_point(24'sh012345, -24'sh054321, 0);
    send_point(24'sh012345, -24'sh054321, 0);
    send_point(24'sh012345, -24'sh054321, 1);
    send_point(24'sh000000, 24'sh000000, 0);
    send_point(24'sh010000, 24'sh010000, 0);
    send_point(24'sh020000, 24'sh020000, 1);
    send_point(24'sh100000, 24'sh000000, 0);
    send_point(24'sh000000, 24'sh100000, 0);
    send_point(-24'sh100000, 24'sh000000, 0);
    send_point(24'sh000000, -24'sh100000, 1);
    send_point(24'sh000001, 24'sh000000, 0);
    send_point(24'sh000000, 24'sh000001, 0);
    send_point(-24'sh000001, -24'sh000001, 1);

    // hold off until every pending fit has come back
    start = 1'b0;
    while (pending != 0) @(negedge clk);

    // random sets, mostly clustered points
    send_set(MAX_PTS, 1);
    send_set(MAX_PTS + 2, 1);
    while (sent < 1750) begin
      calm = (sent > 800 && sent < 1100);
      n = $urandom_range(99);
      if (n < 8) n = $urandom_range(1, 2);
      else if (n < 12) n = $urandom_range(13, 40);
      else n = $urandom_range(3, 12);
      case ($urandom_range(9))
        0, 1: send_set(n, 0);
        2:    send_set(n, 2);
        default: send_set(n, 1);
      endcase
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
